FILE: design/rspdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspdf_pkg
// Shared types, codes and helpers of the packet deframer.
// ----------------------------------------------------------------------------
package rspdf_pkg;

   // payload capacity and field widths
   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned RSP_DATA_W  = 40;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   // input action codes
   localparam logic [1:0] ACT_BYTE      = 2'd0;
   localparam logic [1:0] ACT_LINK_LOST = 2'd1;
   localparam logic [1:0] ACT_KILL      = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
   localparam logic [2:0] KIND_BAD_SUM   = 3'd2;
   localparam logic [2:0] KIND_ABORTED   = 3'd3;
   localparam logic [2:0] KIND_LINK_LOST = 3'd4;
   localparam logic [2:0] KIND_KILL      = 3'd5;

   // framing characters
   localparam logic [7:0] CHAR_START  = 8'h24;
   localparam logic [7:0] CHAR_END    = 8'h23;
   localparam logic [7:0] CHAR_ESCAPE = 8'h7d;
   localparam logic [7:0] ESCAPE_XOR  = 8'h20;
   localparam logic [7:0] CHAR_ACK    = 8'h2b;
   localparam logic [7:0] CHAR_NAK    = 8'h2d;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_DATA = 5'b00010,
      PH_ESC  = 5'b00100,
      PH_CSHI = 5'b01000,
      PH_CSLO = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   // ascii hex digit to nibble, ok low on anything else
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok     = 1'b1;
      r.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nibble = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nibble = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: design/rsp_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer_top
// Receive-side packet deframer: start hunt, escape decode, checksum check.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | carries
//  req_    | in  | req_tvalid/tready    | one rx byte or link event per beat
//  rsp_    | out | rsp_tvalid/tready    | payload byte or end-of-packet status
//  csr_    | in  | csr_valid/ready      | no_ack_mode register write
//
//  one beat per cycle unless the result side stalls: the per-beat rule is a
//  single pass of logic from the phase/sum/count registers into the result
//  register; the result register parts the two sides; a new beat is taken
//  whenever the result register is empty or being drained in the same cycle
//  reset is synchronous active high: hunting, sums and counts cleared,
//  no_ack_mode cleared; csr writes are always taken
// ----------------------------------------------------------------------------
module rsp_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [rspdf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [7:0] payload_byte, [8] send_ack, [16:9] ack_char, [27:17] packet_length,
   // [28] overflowed, [36:29] computed_sum, [39:37] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // [0] no_ack_mode
);

   localparam int unsigned LW = rspdf_pkg::LEN_W;

   // state registers
   rspdf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    sum_ff, sum_in;
   logic [LW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [3:0]    hi_nib_ff, hi_nib_in;
   logic          hex_bad_ff, hex_bad_in;
   logic          no_ack_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    kind_ff;
   logic [7:0]    pbyte_ff;
   logic          ack_ff;
   logic [7:0]    ack_char_ff;
   logic [LW-1:0] len_ff;
   logic          rovf_ff;
   logic [7:0]    rsum_ff;

   // combinational result of the accepted beat
   logic          res_valid;
   logic [2:0]    res_kind;
   logic [7:0]    res_pbyte;
   logic          res_ack;
   logic [7:0]    res_ack_char;

   logic              req_fire;
   logic [1:0]        action;
   logic [7:0]        c;
   logic [7:0]        decoded;
   rspdf_pkg::hex_type hex;
   logic [7:0]        rx_sum;

   assign csr_ready  = 1'b1;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign action     = req_tuser;
   assign c          = req_tdata;
   assign hex        = rspdf_pkg::hex_decode(c);
   assign rx_sum     = {hi_nib_ff, hex.nibble};

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      hi_nib_in    = hi_nib_ff;
      hex_bad_in   = hex_bad_ff;
      res_valid    = 1'b0;
      res_kind     = rspdf_pkg::KIND_PAYLOAD;
      res_pbyte    = 8'd0;
      res_ack      = 1'b0;
      res_ack_char = 8'd0;
      // escaped bytes are flipped, plain bytes pass as they are
      decoded      = (phase_ff == rspdf_pkg::PH_ESC) ? (c ^ rspdf_pkg::ESCAPE_XOR) : c;

      if (req_fire) begin
         if (action == rspdf_pkg::ACT_LINK_LOST) begin
            phase_in  = rspdf_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = rspdf_pkg::KIND_LINK_LOST;
         end else if (action == rspdf_pkg::ACT_KILL) begin
            phase_in  = rspdf_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = rspdf_pkg::KIND_KILL;
         end else if (action == rspdf_pkg::ACT_BYTE) begin
            unique case (phase_ff) inside
               rspdf_pkg::PH_HUNT: begin
                  if (c == rspdf_pkg::CHAR_START) begin
                     phase_in   = rspdf_pkg::PH_DATA;
                     sum_in     = 8'd0;
                     count_in   = '0;
                     ovf_in     = 1'b0;
                     hi_nib_in  = 4'd0;
                     hex_bad_in = 1'b0;
                  end
               end
               rspdf_pkg::PH_DATA, rspdf_pkg::PH_ESC: begin
                  if (phase_ff == rspdf_pkg::PH_DATA && c == rspdf_pkg::CHAR_START) begin
                     // start inside a packet aborts it
                     phase_in  = rspdf_pkg::PH_HUNT;
                     res_valid = 1'b1;
                     res_kind  = rspdf_pkg::KIND_ABORTED;
                  end else if (phase_ff == rspdf_pkg::PH_DATA &&
                               c == rspdf_pkg::CHAR_END) begin
                     phase_in = rspdf_pkg::PH_CSHI;
                  end else begin
                     sum_in = sum_ff + c;
                     if (phase_ff == rspdf_pkg::PH_DATA && c == rspdf_pkg::CHAR_ESCAPE) begin
                        phase_in = rspdf_pkg::PH_ESC;
                     end else begin
                        phase_in = rspdf_pkg::PH_DATA;
                        if (count_ff < rspdf_pkg::MAX_LEN) begin
                           count_in  = count_ff + LW'(1);
                           res_valid = 1'b1;
                           res_kind  = rspdf_pkg::KIND_PAYLOAD;
                           res_pbyte = decoded;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
               end
               rspdf_pkg::PH_CSHI: begin
                  hi_nib_in  = hex.nibble;
                  hex_bad_in = ~hex.ok;
                  phase_in   = rspdf_pkg::PH_CSLO;
               end
               rspdf_pkg::PH_CSLO: begin
                  hex_bad_in = hex_bad_ff | ~hex.ok;
                  phase_in   = rspdf_pkg::PH_HUNT;
                  res_valid  = 1'b1;
                  if (no_ack_ff) begin
                     res_kind = rspdf_pkg::KIND_ACCEPTED;
                  end else if (!hex_bad_in && rx_sum == sum_ff) begin
                     res_kind     = rspdf_pkg::KIND_ACCEPTED;
                     res_ack      = 1'b1;
                     res_ack_char = rspdf_pkg::CHAR_ACK;
                  end else begin
                     res_kind     = rspdf_pkg::KIND_BAD_SUM;
                     res_ack      = 1'b1;
                     res_ack_char = rspdf_pkg::CHAR_NAK;
                  end
               end
               default: begin
                  phase_in = rspdf_pkg::PH_HUNT;
               end
            endcase
         end
         // unused action code: no result, state held
      end
   end

   // a stalled result stays; a new beat replaces a drained one
   assign rsp_valid_in = req_fire ? res_valid : (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rspdf_pkg::PH_HUNT;
         sum_ff       <= 8'd0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         hi_nib_ff    <= 4'd0;
         hex_bad_ff   <= 1'b0;
         no_ack_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         hi_nib_ff    <= hi_nib_in;
         hex_bad_ff   <= hex_bad_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            no_ack_ff <= csr_data;
         end
      end
   end

   // result payload, status fields reflect state after this beat
   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         kind_ff     <= res_kind;
         pbyte_ff    <= res_pbyte;
         ack_ff      <= res_ack;
         ack_char_ff <= res_ack_char;
         len_ff      <= count_in;
         rovf_ff     <= ovf_in;
         rsum_ff     <= sum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {3'd0, rsum_ff, rovf_ff, len_ff, ack_char_ff, ack_ff, pbyte_ff};

   // ---------------------------------------------------------------- checks
   a_ack_only_on_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ack_ff |->
         (kind_ff == rspdf_pkg::KIND_ACCEPTED && ack_char_ff == rspdf_pkg::CHAR_ACK) ||
         (kind_ff == rspdf_pkg::KIND_BAD_SUM && ack_char_ff == rspdf_pkg::CHAR_NAK))
      else $error("ack flagged without a matching status kind");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= rspdf_pkg::MAX_LEN)
      else $error("payload count beyond capacity");

   a_ovf_only_when_full : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == rspdf_pkg::MAX_LEN)
      else $error("overflow set before capacity reached");

   a_event_to_hunt : assert property (@(posedge clock) disable iff (reset)
      req_fire && (action == rspdf_pkg::ACT_LINK_LOST || action == rspdf_pkg::ACT_KILL)
         |=> phase_ff == rspdf_pkg::PH_HUNT && rsp_valid_ff)
      else $error("link event did not return to hunting with a status");

endmodule
